@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a reset that masks the check asynchronously.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/kdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// kdlp_pkg
// Types, constants and helpers for the key debounce / long-press reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kdlp_pkg;

   localparam int NUM_KEYS    = 6;
   localparam int PIN_COUNT   = 6;
   localparam int COUNT_WIDTH = 16;

   localparam int SCAN_KEYS = (NUM_KEYS < PIN_COUNT) ? NUM_KEYS : PIN_COUNT;
   localparam int LONG_W    = 16;
   localparam int DEB_W     = 8;
   localparam int CMP_W     = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;
   localparam int KEY_W     = 3;
   localparam int EVENT_W   = 3;

   localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd15;
   localparam logic [LONG_W-1:0] LONG_RESET     = 16'd3000;

   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_LONG     = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_HELD     = 2'd2
   } phase_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_UP         = 3'd0,
      EV_DOWN       = 3'd1,
      EV_ALARM_EN   = 3'd2,
      EV_FIVE_DAY   = 3'd3,
      EV_TIME       = 3'd4,
      EV_TIME_LONG  = 3'd5,
      EV_ALARM      = 3'd6,
      EV_ALARM_LONG = 3'd7
   } event_type;

   localparam logic [KEY_W-1:0] TIME_SET_KEY  = 3'd4;
   localparam logic [KEY_W-1:0] ALARM_SET_KEY = 3'd5;

   function automatic logic [EVENT_W-1:0] event_code(input logic [KEY_W-1:0] key,
                                                     input logic is_long);
      logic [EVENT_W-1:0] code;
      case (key)
         TIME_SET_KEY:  code = is_long ? EV_TIME_LONG : EV_TIME;
         ALARM_SET_KEY: code = is_long ? EV_ALARM_LONG : EV_ALARM;
         default:       code = EVENT_W'(key);
      endcase
      return code;
   endfunction

endpackage

@@ sv/key_debounce_long_press_top.sv @@
// ----------------------------------------------------------------------------
// key_debounce_long_press_top
// Debounced six-key reader with long-press detection on the two set keys.
// ----------------------------------------------------------------------------
// One request is one sample of the six active-low key pins (one tick). The
// block takes a request every cycle unless req_stall is high; each sample is
// held in the input register, the key state is updated and any event is written
// to the result register, so an event passes the input register and then the
// result register before it shows up on rsp_. A result held by rsp_stall backs
// up into the input register, and req_stall rises only when both registers are full. The first
// pressed key (up, down, alarm enable, five-day, time set, alarm set) is
// latched, checked again after debounce_ticks ticks, then its held ticks are
// counted; release emits one event code, with a long code for the set keys
// when the held count exceeds long_press_ticks. Write the CSRs only while
// idle.
`timescale 1ns / 1ps

module key_debounce_long_press_top
   import kdlp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // sample requests
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIN_COUNT-1:0] req_key_levels,
   // events
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [EVENT_W-1:0]   rsp_key_event,
   // CSR port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [PADDR_W-1:0]   paddr,
   input  logic [PDATA_W-1:0]   pwdata,
   output logic [PDATA_W-1:0]   prdata,
   output logic                 pready
);

   logic                   in_valid_ff, in_valid_in;
   logic [PIN_COUNT-1:0]   levels_ff, levels_in;
   logic                   out_valid_ff, out_valid_in;
   logic [EVENT_W-1:0]     event_ff, event_in;

   logic [DEB_W-1:0]       deb_ff, deb_in;
   logic [LONG_W-1:0]      long_ff, long_in;

   phase_type              phase_ff, phase_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;

   logic                   advance;
   logic                   req_take;
   logic                   csr_wr;

   logic                   key_low;
   logic                   scan_hit;
   logic [KEY_W-1:0]       scan_key;
   logic [COUNT_WIDTH-1:0] tick_sat;
   logic                   deb_done;
   logic                   is_long;
   logic                   emit;

   // ---------------- handshake ----------------
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign levels_in   = req_take ? req_key_levels : levels_ff;

   // ---------------- CSRs ----------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      deb_in  = deb_ff;
      long_in = long_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            CSR_DEBOUNCE: deb_in  = pwdata[DEB_W-1:0];
            CSR_LONG:     long_in = pwdata[LONG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_DEBOUNCE: prdata = PDATA_W'(deb_ff);
         CSR_LONG:     prdata = PDATA_W'(long_ff);
      endcase
   end

   // ---------------- key datapath ----------------
   // an index past the pins reads as pressed
   assign key_low = (key_ff < KEY_W'(PIN_COUNT)) ? !levels_ff[key_ff] : 1'b1;

   always_comb begin
      scan_hit = 1'b0;
      scan_key = '0;
      for (int k = SCAN_KEYS - 1; k >= 0; k--) begin
         if (!levels_ff[k]) begin
            scan_hit = 1'b1;
            scan_key = KEY_W'(k);
         end
      end
   end

   assign tick_sat = (&tick_ff) ? tick_ff : tick_ff + 1'b1;
   assign deb_done = CMP_W'(tick_sat) >= CMP_W'(deb_ff);
   assign is_long  = CMP_W'(tick_ff) > CMP_W'(long_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (phase_ff)
            PH_DEBOUNCE: begin
               if (deb_done)
                  phase_in = key_low ? PH_HELD : PH_IDLE;
            end
            PH_HELD: begin
               if (!key_low)
                  phase_in = PH_IDLE;
            end
            default: begin
               phase_in = scan_hit ? PH_DEBOUNCE : PH_IDLE;
            end
         endcase
      end
   end

   // counter, latched key and event
   always_comb begin
      key_in   = key_ff;
      tick_in  = tick_ff;
      emit     = 1'b0;
      event_in = event_ff;
      if (advance) begin
         unique case (phase_ff)
            PH_DEBOUNCE: begin
               if (!deb_done)
                  tick_in = tick_sat;
               else
                  tick_in = key_low ? COUNT_WIDTH'(1) : '0;
            end
            PH_HELD: begin
               if (key_low) begin
                  tick_in = tick_sat;
               end else begin
                  emit     = 1'b1;
                  event_in = event_code(key_ff, is_long);
                  tick_in  = '0;
               end
            end
            default: begin
               if (scan_hit) begin
                  key_in  = scan_key;
                  tick_in = '0;
               end
            end
         endcase
      end
   end

   assign out_valid_in = emit || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         deb_ff       <= DEBOUNCE_RESET;
         long_ff      <= LONG_RESET;
         phase_ff     <= PH_IDLE;
         key_ff       <= '0;
         tick_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         deb_ff       <= deb_in;
         long_ff      <= long_in;
         phase_ff     <= phase_in;
         key_ff       <= key_in;
         tick_ff      <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
      event_ff  <= event_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_event = event_ff;

endmodule

@@ sv/kdlp_port_checker.sv @@
// ----------------------------------------------------------------------------
// kdlp_port_checker
// Port-level checks for the key debounce / long-press reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module kdlp_port_checker
   import kdlp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [EVENT_W-1:0]   rsp_key_event
);

   // no event survives reset
   `CHK_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> !rsp_valid, "event after reset")

   // request side only backs up behind a stalled event
   `CHK_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "bad stall")

   // an event needs latch, debounce, confirm and release samples
   `CHK_ASSERT(a_event_gap, clock, reset, rsp_valid && !rsp_stall |=> !rsp_valid, "events close")

   `CHK_ASSERT(a_event_gap2, clock, reset, rsp_valid && !rsp_stall |-> ##2 !rsp_valid, "too close")

   // stalled event holds
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_key_event), "moved")

   `CHK_ASSERT(a_rsp_keep, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "event dropped")

endmodule

bind key_debounce_long_press_top kdlp_port_checker u_kdlp_port_checker (.*);
